/* rtl/cpcr_pkg.sv */
// ============================================================================
// cpcr_pkg
// Shared types, widths and helpers for the circle pair collision resolver.
// ============================================================================
package cpcr_pkg;

   localparam int CW         = 32;
   localparam int RADIUS_W   = 23;
   localparam int INV_MASS_W = 25;
   localparam int EPS_W      = 17;
   localparam int CSR_DATA_W = 25;
   localparam int CSR_ADDR_W = 2;

   localparam int DIA_W      = RADIUS_W + 1;
   localparam int DSQ_W      = 2 * DIA_W;
   localparam int DIST_W     = DSQ_W / 2;
   localparam int SQRT_STEPS = DSQ_W / 2;
   localparam int DIR_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int DIV_W      = DIA_W + FRAC_W;
   localparam int OM_W       = DIA_W + DIR_W;
   localparam int FORCE_W    = OM_W + 7 - FRAC_W;
   localparam int PUSH_W     = OM_W - FRAC_W - 1;
   localparam int ACC_W      = FORCE_W + INV_MASS_W - FRAC_W;
   localparam int SUM_W      = ACC_W + 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_INV_MASS = 2'd1,
      CSR_EPSILON  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [CW-1:0] p1_x;
      logic signed [CW-1:0] p1_y;
      logic signed [CW-1:0] p2_x;
      logic signed [CW-1:0] p2_y;
      logic signed [CW-1:0] p1_accel_x;
      logic signed [CW-1:0] p1_accel_y;
      logic signed [CW-1:0] p2_accel_x;
      logic signed [CW-1:0] p2_accel_y;
   } req_type;

   typedef struct packed {
      logic                 collided;
      logic signed [CW-1:0] new_p1_x;
      logic signed [CW-1:0] new_p1_y;
      logic signed [CW-1:0] new_p2_x;
      logic signed [CW-1:0] new_p2_y;
      logic signed [CW-1:0] new_p1_accel_x;
      logic signed [CW-1:0] new_p1_accel_y;
      logic signed [CW-1:0] new_p2_accel_x;
      logic signed [CW-1:0] new_p2_accel_y;
   } rsp_type;

   // Everything one request carries down the pipeline.
   typedef struct packed {
      req_type            item;
      logic               cand;
      logic               hit;
      logic               neg_x;
      logic               neg_y;
      logic [DIA_W-1:0]   ax;
      logic [DIA_W-1:0]   ay;
      logic [DSQ_W-1:0]   dsq;
      logic [DIST_W-1:0]  span;
      logic [DIA_W-1:0]   ovl;
      logic               fallback;
      logic [DIR_W-1:0]   dmag_x;
      logic [DIR_W-1:0]   dmag_y;
      logic [OM_W-1:0]    om_x;
      logic [OM_W-1:0]    om_y;
      logic [PUSH_W-1:0]  push_x;
      logic [PUSH_W-1:0]  push_y;
      logic [FORCE_W-1:0] force_x;
      logic [FORCE_W-1:0] force_y;
      logic [ACC_W-1:0]   acc_x;
      logic [ACC_W-1:0]   acc_y;
   } work_type;

   function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = $signed({{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
      lo = ~hi;
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] sext(input logic signed [CW-1:0] x);
      return $signed({{(SUM_W-CW){x[CW-1]}}, x});
   endfunction

endpackage

/* rtl/circle_pair_collision_resolve.sv */
// ============================================================================
// circle_pair_collision_resolve
// Resolves overlap between two equal circles: push-out and spring force.
// ============================================================================
//  channel  ports                      direction  content
//  req      req_valid/ready/data       in         two particles, pos + accel
//  rsp      rsp_valid/ready/data       out        collided flag, updated fields
//  csr      csr_we/index/wdata         in         radius, inv_mass, epsilon_dist
//
//  One request enters per cycle unless the result side stalls; the pipeline
//  holds the 24-stage square root, the 17-stage divider and seven arithmetic stages.
//  Reset clears all valid bits and loads the register defaults.
//  Each stage holds only while the next one is full and stalled, so bubbles
//  collapse and the input keeps flowing whenever the result is taken.
// ============================================================================
module circle_pair_collision_resolve
   import cpcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RADIUS_W-1:0]   radius_ff;
   logic [INV_MASS_W-1:0] inv_mass_ff;
   logic [EPS_W-1:0]      eps_ff;
   logic [DSQ_W-1:0]      dia_sq_ff;
   logic [DIA_W-1:0]      dia;

   assign dia = {radius_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_W'(327680);
         inv_mass_ff <= INV_MASS_W'(65536);
         eps_ff      <= EPS_W'(66);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            CSR_INV_MASS: inv_mass_ff <= csr_wdata[INV_MASS_W-1:0];
            CSR_EPSILON:  eps_ff      <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
      dia_sq_ff <= DSQ_W'(dia) * DSQ_W'(dia);
   end

   logic     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   work_type w1_ff, w2_ff, w3_ff, w4_ff, w5_ff, w6_ff;
   work_type w1_in, w2_in, w3_in, w4_in, w5_in, w6_in;
   rsp_type  rsp_ff, rsp_in;
   logic     r1, r2, r3, r4, r5, r6, r7;
   logic     sq_in_ready, sq_valid, dv_in_ready, dv_valid;
   work_type sq_work, dv_work;

   assign r7 = !v7_ff || rsp_ready;
   assign r6 = !v6_ff || r7;
   assign r5 = !v5_ff || r6;
   assign r4 = !v4_ff || r5;
   assign r3 = !v3_ff || dv_in_ready;
   assign r2 = !v2_ff || sq_in_ready;
   assign r1 = !v1_ff || r2;

   // Stage 1: differences and magnitudes.
   logic signed [CW:0] dx, dy;
   logic        [CW:0] ax_full, ay_full;

   always_comb begin
      dx = {req_data.p1_x[CW-1], req_data.p1_x} - {req_data.p2_x[CW-1], req_data.p2_x};
      dy = {req_data.p1_y[CW-1], req_data.p1_y} - {req_data.p2_y[CW-1], req_data.p2_y};
      ax_full = dx[CW] ? -dx : dx;
      ay_full = dy[CW] ? -dy : dy;
      w1_in       = '0;
      w1_in.item  = req_data;
      w1_in.neg_x = dx[CW];
      w1_in.neg_y = dy[CW];
      w1_in.ax    = ax_full[DIA_W-1:0];
      w1_in.ay    = ay_full[DIA_W-1:0];
      w1_in.cand  = (ax_full < (CW+1)'(dia)) && (ay_full < (CW+1)'(dia));
   end

   // Stage 2: squared distance and the overlap test.
   logic [DSQ_W-1:0] sq_x, sq_y;

   always_comb begin
      sq_x      = DSQ_W'(w1_ff.ax) * DSQ_W'(w1_ff.ax);
      sq_y      = DSQ_W'(w1_ff.ay) * DSQ_W'(w1_ff.ay);
      w2_in     = w1_ff;
      w2_in.dsq = sq_x + sq_y;
      w2_in.hit = w1_ff.cand && ((sq_x + sq_y) < dia_sq_ff);
   end

   cpcr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_ready  (sq_in_ready),
      .in_work   (w2_ff),
      .out_valid (sq_valid),
      .out_ready (r3),
      .out_work  (sq_work)
   );

   // Stage 3: overlap and the near-coincidence fallback.
   always_comb begin
      w3_in          = sq_work;
      w3_in.ovl      = dia - sq_work.span;
      w3_in.fallback = (sq_work.span == '0) || (DIST_W'(eps_ff) > sq_work.span);
   end

   cpcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (dv_in_ready),
      .in_work   (w3_ff),
      .out_valid (dv_valid),
      .out_ready (r4),
      .out_work  (dv_work)
   );

   // Stage 4: direction select and overlap times direction.
   logic [DIR_W-1:0] dmx, dmy;

   always_comb begin
      w4_in = dv_work;
      if (dv_work.fallback) begin
         dmx         = DIR_W'(65536);
         dmy         = '0;
         w4_in.neg_x = 1'b0;
         w4_in.neg_y = 1'b0;
      end else begin
         dmx = dv_work.dmag_x;
         dmy = dv_work.dmag_y;
      end
      w4_in.om_x = OM_W'(dv_work.ovl) * OM_W'(dmx);
      w4_in.om_y = OM_W'(dv_work.ovl) * OM_W'(dmy);
   end

   // Stage 5: half-overlap push and spring force.
   logic [OM_W+6:0] om80_x, om80_y;

   always_comb begin
      w5_in         = w4_ff;
      om80_x        = (OM_W+7)'(w4_ff.om_x) * (OM_W+7)'(80);
      om80_y        = (OM_W+7)'(w4_ff.om_y) * (OM_W+7)'(80);
      w5_in.push_x  = w4_ff.om_x[OM_W-1:FRAC_W+1];
      w5_in.push_y  = w4_ff.om_y[OM_W-1:FRAC_W+1];
      w5_in.force_x = om80_x[OM_W+6:FRAC_W];
      w5_in.force_y = om80_y[OM_W+6:FRAC_W];
   end

   // Stage 6: force scaled by inverse mass.
   logic [FORCE_W+INV_MASS_W-1:0] fm_x, fm_y;

   always_comb begin
      w6_in       = w5_ff;
      fm_x        = (FORCE_W+INV_MASS_W)'(w5_ff.force_x) * (FORCE_W+INV_MASS_W)'(inv_mass_ff);
      fm_y        = (FORCE_W+INV_MASS_W)'(w5_ff.force_y) * (FORCE_W+INV_MASS_W)'(inv_mass_ff);
      w6_in.acc_x = fm_x[FORCE_W+INV_MASS_W-1:FRAC_W];
      w6_in.acc_y = fm_y[FORCE_W+INV_MASS_W-1:FRAC_W];
   end

   // Stage 7: saturating updates.
   function automatic logic signed [SUM_W-1:0] sterm(input logic [ACC_W-1:0] mag,
                                                     input logic neg);
      logic signed [SUM_W-1:0] t;
      t = $signed(SUM_W'(mag));
      return neg ? -t : t;
   endfunction

   logic signed [SUM_W-1:0] px, py, qx, qy;

   always_comb begin
      px = sterm(ACC_W'(w6_ff.push_x), w6_ff.neg_x);
      py = sterm(ACC_W'(w6_ff.push_y), w6_ff.neg_y);
      qx = sterm(w6_ff.acc_x, w6_ff.neg_x);
      qy = sterm(w6_ff.acc_y, w6_ff.neg_y);
      rsp_in.collided       = w6_ff.hit;
      rsp_in.new_p1_x       = w6_ff.item.p1_x;
      rsp_in.new_p1_y       = w6_ff.item.p1_y;
      rsp_in.new_p2_x       = w6_ff.item.p2_x;
      rsp_in.new_p2_y       = w6_ff.item.p2_y;
      rsp_in.new_p1_accel_x = w6_ff.item.p1_accel_x;
      rsp_in.new_p1_accel_y = w6_ff.item.p1_accel_y;
      rsp_in.new_p2_accel_x = w6_ff.item.p2_accel_x;
      rsp_in.new_p2_accel_y = w6_ff.item.p2_accel_y;
      if (w6_ff.hit) begin
         rsp_in.new_p1_x       = sat(sext(w6_ff.item.p1_x) + px);
         rsp_in.new_p1_y       = sat(sext(w6_ff.item.p1_y) + py);
         rsp_in.new_p2_x       = sat(sext(w6_ff.item.p2_x) - px);
         rsp_in.new_p2_y       = sat(sext(w6_ff.item.p2_y) - py);
         rsp_in.new_p1_accel_x = sat(sext(w6_ff.item.p1_accel_x) + qx);
         rsp_in.new_p1_accel_y = sat(sext(w6_ff.item.p1_accel_y) + qy);
         rsp_in.new_p2_accel_x = sat(sext(w6_ff.item.p2_accel_x) - qx);
         rsp_in.new_p2_accel_y = sat(sext(w6_ff.item.p2_accel_y) - qy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= sq_valid;
         if (r4) v4_ff <= dv_valid;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
         if (r7) v7_ff <= v6_ff;
      end
      if (r1) w1_ff  <= w1_in;
      if (r2) w2_ff  <= w2_in;
      if (r3) w3_ff  <= w3_in;
      if (r4) w4_ff  <= w4_in;
      if (r5) w5_ff  <= w5_in;
      if (r6) w6_ff  <= w6_in;
      if (r7) rsp_ff <= rsp_in;
   end

   assign req_ready = r1;
   assign rsp_valid = v7_ff;
   assign rsp_data  = rsp_ff;

   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while the result side drains");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_dist_below_dia: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && w3_ff.hit) |-> (DIA_W'(w3_ff.span) < dia))
      else $error("square root not below the diameter on a collision");

   a_fallback_dir: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && w4_ff.fallback) |-> (w4_ff.om_y == '0 && !w4_ff.neg_x))
      else $error("fallback direction not (1,0)");

endmodule

/* rtl/cpcr_sqrt.sv */
// ============================================================================
// cpcr_sqrt
// Pipelined integer square root of the squared distance, one result bit
// per stage, with the request carried alongside.
// ============================================================================
module cpcr_sqrt
   import cpcr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   localparam int Steps = SQRT_STEPS;
   localparam int RemW  = DIST_W + 3;

   logic              valid_ff [Steps];
   work_type          work_ff  [Steps];
   logic [RemW-1:0]   rem_ff   [Steps];
   logic [DIST_W-1:0] root_ff  [Steps];
   logic [DSQ_W-1:0]  rad_ff   [Steps];

   logic              src_v    [Steps];
   work_type          src_w    [Steps];
   logic [RemW-1:0]   src_rem  [Steps];
   logic [DIST_W-1:0] src_root [Steps];
   logic [DSQ_W-1:0]  src_rad  [Steps];

   logic [RemW-1:0]   rem_sh   [Steps];
   logic [RemW-1:0]   trial    [Steps];
   logic [RemW-1:0]   rem_in   [Steps];
   logic [DIST_W-1:0] root_in  [Steps];
   logic [Steps:0]    ready;

   always_comb begin
      ready[Steps] = out_ready;
      for (int k = Steps - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      src_v[0]    = in_valid;
      src_w[0]    = in_work;
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_rad[0]  = in_work.dsq;
      for (int k = 1; k < Steps; k++) begin
         src_v[k]    = valid_ff[k-1];
         src_w[k]    = work_ff[k-1];
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
         src_rad[k]  = rad_ff[k-1];
      end
      // Bring down two radicand bits, then try subtracting 4*root + 1.
      for (int k = 0; k < Steps; k++) begin
         rem_sh[k] = {src_rem[k][RemW-3:0], src_rad[k][DSQ_W-1 -: 2]};
         trial[k]  = {1'b0, src_root[k], 2'b01};
         if (rem_sh[k] >= trial[k]) begin
            rem_in[k]  = rem_sh[k] - trial[k];
            root_in[k] = {src_root[k][DIST_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[k];
            root_in[k] = {src_root[k][DIST_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Steps; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_v[k];
         end
         if (ready[k]) begin
            work_ff[k] <= src_w[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= src_rad[k] << 2;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[Steps-1];

   always_comb begin
      out_work      = work_ff[Steps-1];
      out_work.span = root_ff[Steps-1];
   end

endmodule

/* rtl/cpcr_div.sv */
// ============================================================================
// cpcr_div
// Pipelined restoring divider for both direction components, one quotient
// bit per stage, with the request carried alongside.
// ============================================================================
module cpcr_div
   import cpcr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   localparam int Steps = DIR_W;

   logic             valid_ff [Steps];
   work_type         work_ff  [Steps];
   logic [DIV_W-1:0] remx_ff  [Steps];
   logic [DIV_W-1:0] remy_ff  [Steps];
   logic [DIR_W-1:0] qx_ff    [Steps];
   logic [DIR_W-1:0] qy_ff    [Steps];

   logic             src_v    [Steps];
   work_type         src_w    [Steps];
   logic [DIV_W-1:0] src_remx [Steps];
   logic [DIV_W-1:0] src_remy [Steps];
   logic [DIR_W-1:0] src_qx   [Steps];
   logic [DIR_W-1:0] src_qy   [Steps];

   logic [DIV_W-1:0] dvs      [Steps];
   logic [DIV_W-1:0] remx_in  [Steps];
   logic [DIV_W-1:0] remy_in  [Steps];
   logic [DIR_W-1:0] qx_in    [Steps];
   logic [DIR_W-1:0] qy_in    [Steps];
   logic [Steps:0]   ready;

   always_comb begin
      ready[Steps] = out_ready;
      for (int k = Steps - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      src_v[0]    = in_valid;
      src_w[0]    = in_work;
      src_remx[0] = {in_work.ax, {FRAC_W{1'b0}}};
      src_remy[0] = {in_work.ay, {FRAC_W{1'b0}}};
      src_qx[0]   = '0;
      src_qy[0]   = '0;
      for (int k = 1; k < Steps; k++) begin
         src_v[k]    = valid_ff[k-1];
         src_w[k]    = work_ff[k-1];
         src_remx[k] = remx_ff[k-1];
         src_remy[k] = remy_ff[k-1];
         src_qx[k]   = qx_ff[k-1];
         src_qy[k]   = qy_ff[k-1];
      end
      // The quotient never exceeds one in Q1.16, so it fits DIR_W bits.
      for (int k = 0; k < Steps; k++) begin
         dvs[k] = DIV_W'(src_w[k].span) << (Steps - 1 - k);
         if (src_remx[k] >= dvs[k]) begin
            remx_in[k] = src_remx[k] - dvs[k];
            qx_in[k]   = {src_qx[k][DIR_W-2:0], 1'b1};
         end else begin
            remx_in[k] = src_remx[k];
            qx_in[k]   = {src_qx[k][DIR_W-2:0], 1'b0};
         end
         if (src_remy[k] >= dvs[k]) begin
            remy_in[k] = src_remy[k] - dvs[k];
            qy_in[k]   = {src_qy[k][DIR_W-2:0], 1'b1};
         end else begin
            remy_in[k] = src_remy[k];
            qy_in[k]   = {src_qy[k][DIR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Steps; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_v[k];
         end
         if (ready[k]) begin
            work_ff[k] <= src_w[k];
            remx_ff[k] <= remx_in[k];
            remy_ff[k] <= remy_in[k];
            qx_ff[k]   <= qx_in[k];
            qy_ff[k]   <= qy_in[k];
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[Steps-1];

   always_comb begin
      out_work        = work_ff[Steps-1];
      out_work.dmag_x = qx_ff[Steps-1];
      out_work.dmag_y = qy_ff[Steps-1];
   end

endmodule
